FILE: design/wsdefrm_pkg.sv
package wsdefrm_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned LimitW  = 21;
  localparam int unsigned LenW    = 64;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CountW  = 3;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned KeyPosW = 2;

  // parse phase codes, unused codes behave as the first header byte
  localparam logic [PhaseW-1:0] PhHdr0    = 3'd0;
  localparam logic [PhaseW-1:0] PhHdr1    = 3'd1;
  localparam logic [PhaseW-1:0] PhExtLen  = 3'd2;
  localparam logic [PhaseW-1:0] PhKey     = 3'd3;
  localparam logic [PhaseW-1:0] PhPayload = 3'd4;

  // length codes of the second header byte
  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  // byte counts of the extended length and key fields (zero means eight)
  localparam logic [CountW-1:0] Ext16Bytes = 3'd2;
  localparam logic [CountW-1:0] Ext64Bytes = 3'd0;
  localparam logic [CountW-1:0] KeyBytes   = 3'd4;

  // payload limit after reset
  localparam logic [LimitW-1:0] LimitReset = 21'd100000;

endpackage

FILE: design/websocket_frame_deframer.sv
// channel  | direction | signals
// ---------+-----------+-------------------------------------------------------
// stream   | in        | in_valid_i, in_ready_o, stream_byte_i
// payload  | out       | out_valid_o, out_ready_i, payload_byte_o, frame_opcode_o,
//          |           | final_fragment_o, last_of_frame_o
// config   | in        | cfg_valid_i, cfg_ready_o, cfg_payload_limit_i
//
// one stream byte is taken per cycle unless the output stalls; its payload byte
// appears on the output register the cycle after the transfer.
// the throughput is set by the single output register, which frees in the same
// cycle that a waiting result is taken, so one byte per cycle is sustained.
// a stall on the output holds the input off only while the result is not taken.
// reset (rst_ni low, asynchronous) returns the parser to the first header byte
// and the payload limit to 100000.
module websocket_frame_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [wsdefrm_pkg::ByteW-1:0]   stream_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wsdefrm_pkg::ByteW-1:0]   payload_byte_o,
  output logic [wsdefrm_pkg::OpW-1:0]     frame_opcode_o,
  output logic                            final_fragment_o,
  output logic                            last_of_frame_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wsdefrm_pkg::LimitW-1:0]  cfg_payload_limit_i
);

  logic [wsdefrm_pkg::LimitW-1:0]  limit_q;
  logic [wsdefrm_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [wsdefrm_pkg::OpW-1:0]     opcode_q, opcode_d;
  logic                            fin_q, fin_d;
  logic                            mask_q, mask_d;
  logic [wsdefrm_pkg::LenW-1:0]    remaining_q, remaining_d;
  logic [wsdefrm_pkg::CountW-1:0]  count_q, count_d;
  logic [wsdefrm_pkg::KeyW-1:0]    key_q, key_d;
  logic [wsdefrm_pkg::KeyPosW-1:0] key_pos_q, key_pos_d;
  logic                            skip_q, skip_d;

  logic                            out_valid_q;
  logic [wsdefrm_pkg::ByteW-1:0]   out_byte_q;
  logic [wsdefrm_pkg::OpW-1:0]     out_op_q;
  logic                            out_fin_q;
  logic                            out_last_q;

  logic                            in_fire;
  logic                            emit;
  logic                            last;
  logic                            do_after_length;
  logic                            do_begin;
  logic [wsdefrm_pkg::ByteW-1:0]   key_byte;

  // handshakes
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // key byte for the current payload position, first key byte first
  always_comb begin
    case (key_pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // frame parser next state
  always_comb begin
    phase_d         = phase_q;
    opcode_d        = opcode_q;
    fin_d           = fin_q;
    mask_d          = mask_q;
    remaining_d     = remaining_q;
    count_d         = count_q;
    key_d           = key_q;
    key_pos_d       = key_pos_q;
    skip_d          = skip_q;
    emit            = 1'b0;
    last            = 1'b0;
    do_after_length = 1'b0;
    do_begin        = 1'b0;

    case (phase_q)
      wsdefrm_pkg::PhHdr1: begin
        mask_d      = stream_byte_i[7];
        remaining_d = '0;
        if (stream_byte_i[6:0] == wsdefrm_pkg::LenCode16) begin
          count_d = wsdefrm_pkg::Ext16Bytes;
          phase_d = wsdefrm_pkg::PhExtLen;
        end else if (stream_byte_i[6:0] == wsdefrm_pkg::LenCode64) begin
          count_d = wsdefrm_pkg::Ext64Bytes;
          phase_d = wsdefrm_pkg::PhExtLen;
        end else begin
          remaining_d     = {57'd0, stream_byte_i[6:0]};
          do_after_length = 1'b1;
        end
      end
      wsdefrm_pkg::PhExtLen: begin
        remaining_d = {remaining_q[55:0], stream_byte_i};
        count_d     = count_q - 3'd1;
        do_after_length = (count_d == '0);
      end
      wsdefrm_pkg::PhKey: begin
        key_d    = {key_q[23:0], stream_byte_i};
        count_d  = count_q - 3'd1;
        do_begin = (count_d == '0);
      end
      wsdefrm_pkg::PhPayload: begin
        key_pos_d   = key_pos_q + 2'd1;
        remaining_d = remaining_q - 64'd1;
        last        = (remaining_q == 64'd1);
        if (last) begin
          phase_d = wsdefrm_pkg::PhHdr0;
          skip_d  = 1'b0;
        end
        emit = !skip_q;
      end
      default: begin
        fin_d    = stream_byte_i[7];
        opcode_d = stream_byte_i[3:0];
        phase_d  = wsdefrm_pkg::PhHdr1;
      end
    endcase

    // length done: key field next, or straight to the payload
    if (do_after_length) begin
      if (mask_d) begin
        count_d = wsdefrm_pkg::KeyBytes;
        key_d   = '0;
        phase_d = wsdefrm_pkg::PhKey;
      end else begin
        do_begin = 1'b1;
      end
    end

    // payload start: empty frames go back to the header
    if (do_begin) begin
      key_pos_d = '0;
      if (remaining_d == '0) begin
        phase_d = wsdefrm_pkg::PhHdr0;
        skip_d  = 1'b0;
      end else begin
        skip_d  = (remaining_d >= {43'd0, limit_q});
        phase_d = wsdefrm_pkg::PhPayload;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsdefrm_pkg::PhHdr0;
      opcode_q    <= '0;
      fin_q       <= 1'b0;
      mask_q      <= 1'b0;
      remaining_q <= '0;
      count_q     <= '0;
      key_q       <= '0;
      key_pos_q   <= '0;
      skip_q      <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      opcode_q    <= opcode_d;
      fin_q       <= fin_d;
      mask_q      <= mask_d;
      remaining_q <= remaining_d;
      count_q     <= count_d;
      key_q       <= key_d;
      key_pos_q   <= key_pos_d;
      skip_q      <= skip_d;
    end
  end

  // payload limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= wsdefrm_pkg::LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_payload_limit_i;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_byte_q <= mask_q ? (stream_byte_i ^ key_byte) : stream_byte_i;
      out_op_q   <= opcode_q;
      out_fin_q  <= fin_q;
      out_last_q <= last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_byte_q;
  assign frame_opcode_o   = out_op_q;
  assign final_fragment_o = out_fin_q;
  assign last_of_frame_o  = out_last_q;

`ifndef ASSERT_OFF
  // payload phase always has bytes left
  a_payload_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsdefrm_pkg::PhPayload |-> remaining_q != '0)
    else $error("payload phase with zero remaining length");

  // the final payload byte ends the frame and clears skipping
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == wsdefrm_pkg::PhPayload && remaining_q == 64'd1
    |=> phase_q == wsdefrm_pkg::PhHdr0 && !skip_q)
    else $error("frame did not end after its last payload byte");

  // a payload byte of a kept frame appears in the next cycle
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == wsdefrm_pkg::PhPayload && !skip_q
    |=> out_valid_o && last_of_frame_o == $past(remaining_q == 64'd1))
    else $error("payload byte lost or last flag wrong");

  // header, length and key bytes never produce a result
  a_no_header_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q != wsdefrm_pkg::PhPayload |=> !out_valid_o)
    else $error("result produced by a header byte");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // how a frame header encodes its payload length
  typedef enum int unsigned {
    LenShort,
    LenExt16,
    LenExt64
  } len_form_e;

  // one unmasked payload byte as the parser reports it
  typedef struct packed {
    logic [wsdefrm_pkg::ByteW-1:0] data;
    logic [wsdefrm_pkg::OpW-1:0]   opcode;
    logic                          fin;
    logic                          last;
  } payload_beat_t;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 4;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid    = 1'b0;
  logic [wsdefrm_pkg::ByteW-1:0]  stream_byte = '0;
  logic                           out_ready   = 1'b0;
  logic                           cfg_valid   = 1'b0;
  logic [wsdefrm_pkg::LimitW-1:0] cfg_limit   = '0;

  logic                           in_ready;
  logic                           out_valid;
  logic [wsdefrm_pkg::ByteW-1:0]  payload_byte;
  logic [wsdefrm_pkg::OpW-1:0]    frame_opcode;
  logic                           final_fragment;
  logic                           last_of_frame;
  logic                           cfg_ready;

  websocket_frame_deframer u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .stream_byte_i       (stream_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .payload_byte_o      (payload_byte),
    .frame_opcode_o      (frame_opcode),
    .final_fragment_o    (final_fragment),
    .last_of_frame_o     (last_of_frame),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_payload_limit_i (cfg_limit)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stream bytes waiting for the driver and payload bytes waiting for the dut
  logic [wsdefrm_pkg::ByteW-1:0] stream_q[$];
  payload_beat_t                 expected_beats_q[$];

  int unsigned planned_bytes  = 0;
  int unsigned planned_frames = 0;
  int unsigned bytes_taken    = 0;
  int unsigned beats_checked  = 0;
  int unsigned limit_writes   = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  bit          in_took        = 1'b0;

  // parser state mirrored by the predictor
  logic [wsdefrm_pkg::LimitW-1:0]  ps_limit = wsdefrm_pkg::LimitReset;
  logic [wsdefrm_pkg::PhaseW-1:0]  ps_phase = wsdefrm_pkg::PhHdr0;
  logic [wsdefrm_pkg::OpW-1:0]     ps_op    = '0;
  logic                            ps_fin   = 1'b0;
  logic                            ps_mask  = 1'b0;
  logic [wsdefrm_pkg::LenW-1:0]    ps_len   = '0;
  logic [wsdefrm_pkg::CountW-1:0]  ps_count = '0;
  logic [wsdefrm_pkg::KeyW-1:0]    ps_key   = '0;
  logic [wsdefrm_pkg::KeyPosW-1:0] ps_pos   = '0;
  logic                            ps_skip  = 1'b0;

  // enter the payload, or go back to the header on an empty frame
  task automatic start_payload();
    ps_pos = '0;
    if (ps_len == '0) begin
      ps_phase = wsdefrm_pkg::PhHdr0;
      ps_skip  = 1'b0;
    end else begin
      ps_skip  = (ps_len >= wsdefrm_pkg::LenW'(ps_limit));
      ps_phase = wsdefrm_pkg::PhPayload;
    end
  endtask

  // length known: collect the key if the frame is masked
  task automatic finish_length();
    if (ps_mask) begin
      ps_count = wsdefrm_pkg::KeyBytes;
      ps_key   = '0;
      ps_phase = wsdefrm_pkg::PhKey;
    end else begin
      start_payload();
    end
  endtask

  // advance the parser by one stream byte and queue the payload byte it yields
  task automatic deframe_byte(input logic [wsdefrm_pkg::ByteW-1:0] b);
    logic [wsdefrm_pkg::ByteW-1:0] keyb;
    logic                          last;
    payload_beat_t                 beat;
    case (ps_phase)
      wsdefrm_pkg::PhHdr1: begin
        ps_mask = b[7];
        ps_len  = '0;
        if (b[6:0] == wsdefrm_pkg::LenCode16) begin
          ps_count = wsdefrm_pkg::Ext16Bytes;
          ps_phase = wsdefrm_pkg::PhExtLen;
        end else if (b[6:0] == wsdefrm_pkg::LenCode64) begin
          ps_count = wsdefrm_pkg::Ext64Bytes;
          ps_phase = wsdefrm_pkg::PhExtLen;
        end else begin
          ps_len = wsdefrm_pkg::LenW'(b[6:0]);
          finish_length();
        end
      end
      wsdefrm_pkg::PhExtLen: begin
        ps_len   = {ps_len[wsdefrm_pkg::LenW-wsdefrm_pkg::ByteW-1:0], b};
        ps_count = ps_count - 1'b1;
        if (ps_count == '0) finish_length();
      end
      wsdefrm_pkg::PhKey: begin
        ps_key   = {ps_key[wsdefrm_pkg::KeyW-wsdefrm_pkg::ByteW-1:0], b};
        ps_count = ps_count - 1'b1;
        if (ps_count == '0) start_payload();
      end
      wsdefrm_pkg::PhPayload: begin
        keyb   = ps_mask ? ps_key[8*(3-ps_pos) +: 8] : '0;
        ps_pos = ps_pos + 1'b1;
        ps_len = ps_len - 1'b1;
        last   = (ps_len == '0);
        if (last) ps_phase = wsdefrm_pkg::PhHdr0;
        if (ps_skip) begin
          if (last) ps_skip = 1'b0;
        end else begin
          beat.data   = b ^ keyb;
          beat.opcode = ps_op;
          beat.fin    = ps_fin;
          beat.last   = last;
          expected_beats_q.push_back(beat);
        end
      end
      default: begin
        ps_fin   = b[7];
        ps_op    = b[3:0];
        ps_phase = wsdefrm_pkg::PhHdr1;
      end
    endcase
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: checks payload transfers, feeds the predictor, runs the watchdog
  always @(posedge clk_i) begin : watch
    payload_beat_t want;
    bit            out_took;
    bit            cfg_took;
    if (rst_ni) begin
      in_took  = in_valid && in_ready;
      out_took = out_valid && out_ready;
      cfg_took = cfg_valid && cfg_ready;
      if (cfg_took) ps_limit = cfg_limit;
      if (out_took) begin
        beats_checked++;
        if (expected_beats_q.size() == 0) begin
          $display({"%0t: unexpected payload byte, expected none, ",
                    "actual 0x%0h op 0x%0h fin %0b last %0b"},
                   $time, payload_byte, frame_opcode, final_fragment, last_of_frame);
          mismatches++;
        end else begin
          want = expected_beats_q.pop_front();
          check_field("payload_byte", want.data, payload_byte);
          check_field("frame_opcode", want.opcode, frame_opcode);
          check_field("final_fragment", want.fin, final_fragment);
          check_field("last_of_frame", want.last, last_of_frame);
        end
      end
      if (in_took) begin
        deframe_byte(stream_byte);
        bytes_taken++;
      end
      if (in_took || out_took || cfg_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d payload bytes outstanding",
                 $time, idle_cycles, expected_beats_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stream driver: bursts of random length with random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : drive
    logic                          nv;
    logic [wsdefrm_pkg::ByteW-1:0] nb;
    nv = in_valid;
    nb = stream_byte;
    if (!in_valid || in_took) begin
      nv = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (stream_q.size() != 0) begin
        nv = 1'b1;
        nb = stream_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        end else begin
          burst_left--;
        end
      end
    end
    in_valid    <= nv;
    stream_byte <= nb;
  end

  // payload receiver: rotating ready pattern, replaced now and then
  logic [7:0]  ready_pat = 8'hFF;
  int unsigned pat_left  = 0;

  always @(negedge clk_i) begin
    if (pat_left == 0) begin
      pat_left  = $urandom_range(16, 80);
      ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    end else begin
      pat_left--;
    end
    ready_pat = {ready_pat[0], ready_pat[7:1]};
    out_ready <= ready_pat[0];
  end

  task automatic send_byte(input logic [wsdefrm_pkg::ByteW-1:0] b);
    stream_q.push_back(b);
    planned_bytes++;
  endtask

  // one frame: header, length field, optional key, body bytes of random content
  task automatic push_frame(input logic [wsdefrm_pkg::ByteW-1:0] hdr0, input logic masked,
                            input len_form_e form, input logic [wsdefrm_pkg::LenW-1:0] len,
                            input int unsigned body);
    send_byte(hdr0);
    case (form)
      LenShort: send_byte({masked, len[6:0]});
      LenExt16: begin
        send_byte({masked, wsdefrm_pkg::LenCode16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wsdefrm_pkg::LenCode64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) repeat (4) send_byte(8'($urandom_range(0, 255)));
    repeat (body) send_byte(8'($urandom_range(0, 255)));
    planned_frames++;
  endtask

  // random header bits, mostly short bodies, non-minimal length encodings too
  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    len_form_e   form;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 0;
    else if (pick < 80) len = $urandom_range(1, 12);
    else if (pick < 97) len = $urandom_range(13, 60);
    else len = $urandom_range(126, 150);
    pick = $urandom_range(0, 99);
    if (len >= 126) begin
      if (pick < 50) form = LenExt16;
      else form = LenExt64;
    end else if (pick < 70) begin
      form = LenShort;
    end else if (pick < 85) begin
      form = LenExt16;
    end else begin
      form = LenExt64;
    end
    push_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form,
               wsdefrm_pkg::LenW'(len), len);
  endtask

  task automatic random_frames(input int unsigned budget);
    int unsigned start;
    start = planned_bytes;
    while (planned_bytes - start < budget) random_frame();
  endtask

  // wait until every byte is in and every payload byte is out, then settle
  task automatic wait_drained();
    while (stream_q.size() != 0 || in_valid || expected_beats_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // limit write while the parser is idle
  task automatic change_limit(input logic [wsdefrm_pkg::LimitW-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames at the reset limit
    push_frame(8'h81, 1'b0, LenShort, 64'd0, 0);    // empty text frame
    push_frame(8'h01, 1'b0, LenShort, 64'd3, 3);    // unmasked, not final
    push_frame(8'hFF, 1'b1, LenShort, 64'd5, 5);    // reserved bits set, opcode 15
    push_frame(8'h88, 1'b1, LenExt16, 64'd2, 2);    // close, 16-bit length
    push_frame(8'h09, 1'b0, LenExt64, 64'd1, 1);    // ping, 64-bit length
    push_frame(8'h72, 1'b1, LenExt16, 64'd0, 0);    // empty masked frame
    random_frames(25);

    // every nonempty frame too long
    change_limit(21'd1);
    random_frames(25);

    // limit of 1048576, below the largest 21-bit limit
    change_limit(21'd1048576);
    random_frames(25);

    // lengths around a small limit, then a long skipped masked frame
    change_limit(21'd5);
    push_frame(8'h82, 1'b1, LenShort, 64'd4, 4);
    push_frame(8'h82, 1'b1, LenShort, 64'd5, 5);
    push_frame(8'h02, 1'b0, LenShort, 64'd6, 6);
    push_frame(8'h81, 1'b1, LenExt16, 64'd130, 130);
    random_frames(25);

    change_limit(wsdefrm_pkg::LimitW'($urandom_range(1, 64)));
    random_frames(25);

    change_limit(wsdefrm_pkg::LimitW'($urandom_range(1, 1048576)));
    random_frames(25);
    // 64-bit length with the top bit set: skipped for the rest of the run
    push_frame(8'h82, 1'b1, LenExt64, {1'b1, 63'($urandom)}, 16);

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("covered %0d frames, %0d stream bytes in, %0d payload bytes checked",
             planned_frames, bytes_taken, beats_checked);
    $display("payload limit written %0d times, %0d mismatches, %0d left over",
             limit_writes, mismatches, expected_beats_q.size());
    if (mismatches == 0 && expected_beats_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: websocket_frame_deframer.f
design/wsdefrm_pkg.sv
design/websocket_frame_deframer.sv
dv/tb_top.sv
